[design/nqpt_pkg.sv]
// Package for the NVMe queue pair tracker: field widths, register indexes,
// mode and outcome codes, and the status struct of the pointer wrap unit.
// Depends on nothing; every other design file imports it.
package nqpt_pkg;

  localparam int unsigned MAX_QUEUE_DEPTH = 4096;
  localparam int unsigned QUEUE_PAIRS     = 2;

  localparam int unsigned DEPTH_W = 13;
  localparam int unsigned PTR_W   = 12;
  localparam int unsigned SHIFT_W = 5;
  localparam int unsigned LIMIT_W = 32;
  localparam int unsigned TAG_W   = 16;
  localparam int unsigned ADDR_W  = 19;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned BIT_CNT_W  = 4;

  localparam logic [ADDR_W-1:0]  DOORBELL_BASE   = ADDR_W'(32'h1000);
  localparam logic [DEPTH_W-1:0] DEPTH_MIN       = DEPTH_W'(2);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX       = DEPTH_W'(MAX_QUEUE_DEPTH);
  localparam logic [SHIFT_W-1:0] SHIFT_MIN       = SHIFT_W'(2);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX       = SHIFT_W'(17);
  localparam logic [DEPTH_W-1:0] RST_QUEUE_DEPTH = DEPTH_W'(64);
  localparam logic [SHIFT_W-1:0] RST_STRIDE      = SHIFT_W'(2);
  localparam logic [LIMIT_W-1:0] RST_POLL_LIMIT  = LIMIT_W'(1000000);

  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_SHIFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT   = 2'd2;

  localparam logic MODE_SUBMIT = 1'b0;
  localparam logic MODE_POLL   = 1'b1;

  localparam logic SIDE_TAIL = 1'b0;
  localparam logic SIDE_HEAD = 1'b1;

  typedef enum logic [2:0] {
    OUT_SUBMITTED = 3'd0,
    OUT_PENDING   = 3'd1,
    OUT_COMPLETED = 3'd2,
    OUT_DEV_ERROR = 3'd3,
    OUT_TIMEOUT   = 3'd4,
    OUT_INVALID   = 3'd5
  } outcome_e;

  // Status of the tail successor recompute that follows a depth write.
  typedef struct packed {
    logic                            busy;
    logic                            done;
    logic [QUEUE_PAIRS-1:0][PTR_W-1:0] rem;
  } wrap_status_t;

endpackage

[design/nqpt_cmd_if.sv]
// Command channel of the queue pair tracker: submit or poll transactions.
// Depends on nqpt_pkg for the field widths.
interface nqpt_cmd_if;
  import nqpt_pkg::*;

  logic             valid;
  logic             ready;
  logic             mode;
  logic             queue_sel;
  logic [TAG_W-1:0] entry_status;
  logic [TAG_W-1:0] entry_command_id;
  logic [TAG_W-1:0] entry_queue_id;
  logic             controller_fatal;

  modport source (
    output valid, mode, queue_sel, entry_status, entry_command_id, entry_queue_id,
           controller_fatal,
    input  ready
  );
  modport sink (
    input  valid, mode, queue_sel, entry_status, entry_command_id, entry_queue_id,
           controller_fatal,
    output ready
  );
endinterface

[design/nqpt_rsp_if.sv]
// Result channel of the queue pair tracker: outcome, tag, slot and doorbell.
// Depends on nqpt_pkg for the field widths and the outcome type.
interface nqpt_rsp_if;
  import nqpt_pkg::*;

  logic              valid;
  logic              ready;
  outcome_e          outcome;
  logic [TAG_W-1:0]  command_tag;
  logic [PTR_W-1:0]  slot_index;
  logic              doorbell_write;
  logic [ADDR_W-1:0] doorbell_addr;
  logic [PTR_W-1:0]  doorbell_value;

  modport source (
    output valid, outcome, command_tag, slot_index, doorbell_write, doorbell_addr,
           doorbell_value,
    input  ready
  );
  modport sink (
    input  valid, outcome, command_tag, slot_index, doorbell_write, doorbell_addr,
           doorbell_value,
    output ready
  );
endinterface

[design/nqpt_cfg_if.sv]
// Configuration write channel of the queue pair tracker: register index and data.
// Depends on nqpt_pkg for the index and data widths.
interface nqpt_cfg_if;
  import nqpt_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[design/nqpt_wrap_unit.sv]
// Restoring remainder unit: (tail + 1) mod depth for both queue pairs, one bit a cycle.
// Depends on nqpt_pkg; started by the top level on every queue depth write.
module nqpt_wrap_unit (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             start_i,
  input  logic [nqpt_pkg::DEPTH_W-1:0]                     depth_i,
  input  logic [nqpt_pkg::QUEUE_PAIRS-1:0][nqpt_pkg::PTR_W-1:0] tail_i,
  output nqpt_pkg::wrap_status_t                           status_o
);
  import nqpt_pkg::*;

  logic                 busy_q;
  logic [BIT_CNT_W-1:0] cnt_q;
  logic [QUEUE_PAIRS-1:0][PTR_W-1:0] rem_q;
  logic [QUEUE_PAIRS-1:0][PTR_W-1:0] rem_d;

  always_comb begin
    logic [DEPTH_W-1:0] num;
    logic [DEPTH_W-1:0] shifted;
    for (int q = 0; q < QUEUE_PAIRS; q++) begin
      num     = {1'b0, tail_i[q]} + DEPTH_W'(1);
      shifted = {rem_q[q], num[cnt_q]};
      // subtract when the partial remainder reaches the divisor
      if (shifted >= depth_i) begin
        shifted = shifted - depth_i;
      end
      rem_d[q] = shifted[PTR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= BIT_CNT_W'(DEPTH_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - BIT_CNT_W'(1);
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
    end
  end

  assign status_o.busy = busy_q;
  assign status_o.done = busy_q && (cnt_q == '0) && !start_i;
  assign status_o.rem  = rem_d;

endmodule

[design/nvme_queue_pair_tracker.sv]
// NVMe host queue pair tracker, admin and I/O pairs. A result is registered and
// offered in the cycle after its command is accepted; one command per cycle while
// results are taken, and a result left waiting holds the command channel.
// A queue depth write holds the command channel off while the
// bit-serial remainder unit recomputes each tail successor.
// Reset (async, active low) loads register defaults and resets all queue state.
module nvme_queue_pair_tracker (
  input  logic    clk_i,
  input  logic    rst_ni,
  nqpt_cmd_if.sink   cmd_i,
  nqpt_cfg_if.sink   cfg_i,
  nqpt_rsp_if.source rsp_o
);
  import nqpt_pkg::*;

  // configuration
  logic [DEPTH_W-1:0] queue_depth_q;
  logic [SHIFT_W-1:0] stride_shift_q;
  logic [LIMIT_W-1:0] poll_limit_q;

  // queue state
  logic [TAG_W-1:0]                    last_tag_q, last_tag_d;
  logic [QUEUE_PAIRS-1:0][PTR_W-1:0]   tail_q, tail_d;
  logic [QUEUE_PAIRS-1:0][PTR_W-1:0]   tail_next_q, tail_next_d;
  logic [QUEUE_PAIRS-1:0][PTR_W-1:0]   head_q, head_d;
  logic [QUEUE_PAIRS-1:0]              phase_q, phase_d;
  logic [QUEUE_PAIRS-1:0][TAG_W-1:0]   wait_tag_q, wait_tag_d;
  logic [QUEUE_PAIRS-1:0]              wait_flag_q, wait_flag_d;
  logic [QUEUE_PAIRS-1:0][LIMIT_W-1:0] poll_cnt_q, poll_cnt_d;

  // result register
  logic              rsp_valid_q;
  outcome_e          outcome_q, outcome_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  logic [PTR_W-1:0]  slot_q, slot_d;
  logic              bell_q, bell_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [PTR_W-1:0]  value_q, value_d;

  logic               cmd_acc;
  logic               cfg_acc;
  logic               depth_wr;
  logic [DEPTH_W-1:0] depth;
  logic [SHIFT_W-1:0] shift;
  logic [LIMIT_W-1:0] limit;
  wrap_status_t       wrap;

  always_comb begin
    depth = queue_depth_q;
    if (depth < DEPTH_MIN) depth = DEPTH_MIN;
    if (depth > DEPTH_MAX) depth = DEPTH_MAX;
    shift = stride_shift_q;
    if (shift < SHIFT_MIN) shift = SHIFT_MIN;
    if (shift > SHIFT_MAX) shift = SHIFT_MAX;
    limit = (poll_limit_q == '0) ? LIMIT_W'(1) : poll_limit_q;
  end

  function automatic logic [ADDR_W-1:0] bell_addr(input logic q, input logic side,
                                                   input logic [SHIFT_W-1:0] sh);
    logic [ADDR_W-1:0] reg_idx;
    reg_idx = {{(ADDR_W-2){1'b0}}, q, side};
    return DOORBELL_BASE + (reg_idx << sh);
  endfunction

  assign cfg_i.ready = 1'b1;
  assign cfg_acc     = cfg_i.valid && cfg_i.ready;
  assign depth_wr    = cfg_acc && (cfg_i.index == CFG_QUEUE_DEPTH);
  assign cmd_i.ready = !wrap.busy && (!rsp_valid_q || rsp_o.ready);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;

  nqpt_wrap_unit u_wrap (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (depth_wr),
    .depth_i  (depth),
    .tail_i   (tail_q),
    .status_o (wrap)
  );

  always_comb begin
    logic               q;
    logic [TAG_W-1:0]   new_tag;
    logic [DEPTH_W-1:0] tail_inc;
    logic [DEPTH_W-1:0] head_inc;
    logic [LIMIT_W-1:0] cnt_inc;
    logic               bad;

    last_tag_d  = last_tag_q;
    tail_d      = tail_q;
    tail_next_d = tail_next_q;
    head_d      = head_q;
    phase_d     = phase_q;
    wait_tag_d  = wait_tag_q;
    wait_flag_d = wait_flag_q;
    poll_cnt_d  = poll_cnt_q;

    outcome_d = OUT_INVALID;
    tag_d     = '0;
    slot_d    = '0;
    bell_d    = 1'b0;
    addr_d    = '0;
    value_d   = '0;

    q        = cmd_i.queue_sel;
    new_tag  = last_tag_q + TAG_W'(1);
    if (new_tag == '0) new_tag = TAG_W'(1);
    tail_inc = {1'b0, tail_next_q[q]} + DEPTH_W'(1);
    head_inc = {1'b0, head_q[q]} + DEPTH_W'(1);
    cnt_inc  = poll_cnt_q[q] + LIMIT_W'(1);
    bad      = (cmd_i.entry_command_id != wait_tag_q[q]) ||
               (cmd_i.entry_queue_id != {{(TAG_W-1){1'b0}}, q}) ||
               (cmd_i.entry_status[TAG_W-1:1] != '0);

    if (cmd_acc) begin
      if (cmd_i.mode == MODE_SUBMIT) begin
        if (wait_flag_q[q]) begin
          tag_d = wait_tag_q[q];
        end else begin
          last_tag_d     = new_tag;
          tail_d[q]      = tail_next_q[q];
          tail_next_d[q] = (tail_inc == depth) ? '0 : tail_inc[PTR_W-1:0];
          wait_tag_d[q]  = new_tag;
          wait_flag_d[q] = 1'b1;
          poll_cnt_d[q]  = '0;
          outcome_d      = OUT_SUBMITTED;
          tag_d          = new_tag;
          slot_d         = tail_q[q];
          bell_d         = 1'b1;
          addr_d         = bell_addr(q, SIDE_TAIL, shift);
          value_d        = tail_next_q[q];
        end
      end else if (wait_flag_q[q]) begin
        tag_d = wait_tag_q[q];
        if (cmd_i.entry_status[0] == phase_q[q]) begin
          wait_flag_d[q] = 1'b0;
          poll_cnt_d[q]  = '0;
          if (bad) begin
            outcome_d = OUT_DEV_ERROR;
          end else begin
            // wrap the head and flip the phase at the ring end
            if (head_inc >= depth) begin
              head_d[q]  = '0;
              phase_d[q] = !phase_q[q];
            end else begin
              head_d[q] = head_inc[PTR_W-1:0];
            end
            outcome_d = OUT_COMPLETED;
            bell_d    = 1'b1;
            addr_d    = bell_addr(q, SIDE_HEAD, shift);
            value_d   = (head_inc >= depth) ? '0 : head_inc[PTR_W-1:0];
          end
        end else if (cmd_i.controller_fatal) begin
          wait_flag_d[q] = 1'b0;
          poll_cnt_d[q]  = '0;
          outcome_d      = OUT_DEV_ERROR;
        end else if (cnt_inc >= limit) begin
          wait_flag_d[q] = 1'b0;
          poll_cnt_d[q]  = '0;
          outcome_d      = OUT_TIMEOUT;
        end else begin
          poll_cnt_d[q] = cnt_inc;
          outcome_d     = OUT_PENDING;
        end
      end
    end

    // commands are held off while busy, so the recompute never races a submit
    if (wrap.done) begin
      tail_next_d = wrap.rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_depth_q  <= RST_QUEUE_DEPTH;
      stride_shift_q <= RST_STRIDE;
      poll_limit_q   <= RST_POLL_LIMIT;
    end else if (cfg_acc) begin
      case (cfg_i.index)
        CFG_QUEUE_DEPTH:  queue_depth_q  <= cfg_i.data[DEPTH_W-1:0];
        CFG_STRIDE_SHIFT: stride_shift_q <= cfg_i.data[SHIFT_W-1:0];
        CFG_POLL_LIMIT:   poll_limit_q   <= cfg_i.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_tag_q  <= '0;
      tail_q      <= '0;
      for (int q = 0; q < QUEUE_PAIRS; q++) begin
        tail_next_q[q] <= PTR_W'(1);
      end
      head_q      <= '0;
      phase_q     <= '1;
      wait_tag_q  <= '0;
      wait_flag_q <= '0;
      poll_cnt_q  <= '0;
    end else begin
      last_tag_q  <= last_tag_d;
      tail_q      <= tail_d;
      tail_next_q <= tail_next_d;
      head_q      <= head_d;
      phase_q     <= phase_d;
      wait_tag_q  <= wait_tag_d;
      wait_flag_q <= wait_flag_d;
      poll_cnt_q  <= poll_cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_acc) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_acc) begin
      outcome_q <= outcome_d;
      tag_q     <= tag_d;
      slot_q    <= slot_d;
      bell_q    <= bell_d;
      addr_q    <= addr_d;
      value_q   <= value_d;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.outcome        = outcome_q;
  assign rsp_o.command_tag    = tag_q;
  assign rsp_o.slot_index     = slot_q;
  assign rsp_o.doorbell_write = bell_q;
  assign rsp_o.doorbell_addr  = addr_q;
  assign rsp_o.doorbell_value = value_q;

endmodule

[tb/sv/testbench.sv]
// Self-checking bench for nvme_queue_pair_tracker: drives submit and poll commands
// and register writes, predicts every outcome and doorbell write, checks each result.
// Depends on nqpt_pkg and the nqpt_cmd_if, nqpt_cfg_if and nqpt_rsp_if interfaces.
module testbench;
  import nqpt_pkg::*;

  localparam int STALL_LIMIT    = 5000;
  localparam int HOLD_CYCLES    = 200;
  localparam int PHASES         = 6;
  localparam int PHASE_ITEMS    = 88;
  localparam bit ADMIN_Q        = 1'b0;
  localparam bit IO_Q           = 1'b1;

  typedef struct {
    bit             mode;
    bit             queue_sel;
    bit [TAG_W-1:0] status;
    bit [TAG_W-1:0] entry_cid;
    bit [TAG_W-1:0] entry_qid;
    bit             fatal;
  } command_t;

  typedef struct {
    outcome_e          outcome;
    bit [TAG_W-1:0]    tag;
    bit [PTR_W-1:0]    slot;
    bit                bell;
    bit [ADDR_W-1:0]   addr;
    bit [PTR_W-1:0]    value;
  } result_t;

  class tracker_scoreboard;
    bit [DEPTH_W-1:0] depth_reg;
    bit [SHIFT_W-1:0] shift_reg;
    bit [LIMIT_W-1:0] limit_reg;
    bit [TAG_W-1:0]   last_tag;
    int unsigned      tail [QUEUE_PAIRS];
    int unsigned      head [QUEUE_PAIRS];
    bit               exp_phase [QUEUE_PAIRS];
    bit [TAG_W-1:0]   wait_tag [QUEUE_PAIRS];
    bit               waiting [QUEUE_PAIRS];
    int unsigned      polls [QUEUE_PAIRS];
    result_t          awaited [$];
    int               errors;

    function new();
      depth_reg = RST_QUEUE_DEPTH;
      shift_reg = RST_STRIDE;
      limit_reg = RST_POLL_LIMIT;
      last_tag  = '0;
      errors    = 0;
      for (int i = 0; i < QUEUE_PAIRS; i++) begin
        tail[i]      = 0;
        head[i]      = 0;
        exp_phase[i] = 1'b1;
        wait_tag[i]  = '0;
        waiting[i]   = 1'b0;
        polls[i]     = 0;
      end
    endfunction

    function void set_register(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_QUEUE_DEPTH:  depth_reg = data[DEPTH_W-1:0];
        CFG_STRIDE_SHIFT: shift_reg = data[SHIFT_W-1:0];
        CFG_POLL_LIMIT:   limit_reg = data[LIMIT_W-1:0];
        default: ;
      endcase
    endfunction

    function bit [ADDR_W-1:0] bell_addr(bit q, bit side);
      int unsigned s;
      int unsigned slot;
      s = shift_reg;
      if (s < SHIFT_MIN) s = SHIFT_MIN;
      if (s > SHIFT_MAX) s = SHIFT_MAX;
      slot = 2 * int'(q) + int'(side);
      return ADDR_W'(int'(DOORBELL_BASE) + (slot << s));
    endfunction

    // Advance the tracker state by one accepted command and hold its result.
    function void note_command(command_t c);
      result_t     r;
      int unsigned depth;
      int unsigned limit;
      int unsigned nxt;
      bit          q;
      q = c.queue_sel;
      r.outcome = OUT_INVALID;
      r.tag = '0;
      r.slot = '0;
      r.bell = 1'b0;
      r.addr = '0;
      r.value = '0;
      depth = depth_reg;
      if (depth < DEPTH_MIN) depth = DEPTH_MIN;
      if (depth > DEPTH_MAX) depth = DEPTH_MAX;
      if (c.mode == MODE_SUBMIT) begin
        if (waiting[q]) begin
          r.tag = wait_tag[q];
        end else begin
          last_tag = last_tag + 1'b1;
          if (last_tag == '0) last_tag = TAG_W'(1);
          r.slot = PTR_W'(tail[q]);
          tail[q] = (tail[q] + 1) % depth;
          wait_tag[q] = last_tag;
          waiting[q] = 1'b1;
          polls[q] = 0;
          r.outcome = OUT_SUBMITTED;
          r.tag = last_tag;
          r.bell = 1'b1;
          r.addr = bell_addr(q, SIDE_TAIL);
          r.value = PTR_W'(tail[q]);
        end
      end else if (!waiting[q]) begin
        r.outcome = OUT_INVALID;
      end else if (c.status[0] == exp_phase[q]) begin
        r.tag = wait_tag[q];
        waiting[q] = 1'b0;
        polls[q] = 0;
        if (c.entry_cid != wait_tag[q] || c.entry_qid != TAG_W'(q)
            || c.status[TAG_W-1:1] != '0) begin
          r.outcome = OUT_DEV_ERROR;
        end else begin
          nxt = head[q] + 1;
          if (nxt >= depth) begin
            nxt = 0;
            exp_phase[q] = ~exp_phase[q];
          end
          head[q] = nxt;
          r.outcome = OUT_COMPLETED;
          r.bell = 1'b1;
          r.addr = bell_addr(q, SIDE_HEAD);
          r.value = PTR_W'(nxt);
        end
      end else if (c.fatal) begin
        r.tag = wait_tag[q];
        waiting[q] = 1'b0;
        polls[q] = 0;
        r.outcome = OUT_DEV_ERROR;
      end else begin
        limit = (limit_reg == '0) ? 1 : limit_reg;
        r.tag = wait_tag[q];
        polls[q] = polls[q] + 1;
        if (polls[q] >= limit) begin
          waiting[q] = 1'b0;
          polls[q] = 0;
          r.outcome = OUT_TIMEOUT;
        end else begin
          r.outcome = OUT_PENDING;
        end
      end
      awaited.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_result(result_t got);
      result_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing outstanding: outcome %0d tag %h",
                         got.outcome, got.tag));
        return;
      end
      want = awaited.pop_front();
      if (got.outcome != want.outcome)
        report($sformatf("outcome %0d, expected %0d", got.outcome, want.outcome));
      if (got.tag != want.tag)
        report($sformatf("command_tag %h, expected %h", got.tag, want.tag));
      if (got.slot != want.slot)
        report($sformatf("slot_index %0d, expected %0d", got.slot, want.slot));
      if (got.bell != want.bell)
        report($sformatf("doorbell_write %0b, expected %0b", got.bell, want.bell));
      if (got.addr != want.addr)
        report($sformatf("doorbell_addr %h, expected %h", got.addr, want.addr));
      if (got.value != want.value)
        report($sformatf("doorbell_value %0d, expected %0d", got.value, want.value));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   hold_req = 1'b0;
  int   idle_cycles = 0;
  tracker_scoreboard sb;

  nqpt_cmd_if cmd();
  nqpt_cfg_if cfg();
  nqpt_rsp_if rsp();

  nvme_queue_pair_tracker dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cmd_i (cmd),
    .cfg_i (cfg),
    .rsp_o (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function command_t submit_cmd(bit q);
    command_t c;
    c.mode = MODE_SUBMIT;
    c.queue_sel = q;
    c.status = TAG_W'($urandom);
    c.entry_cid = TAG_W'($urandom);
    c.entry_qid = TAG_W'($urandom);
    c.fatal = 1'($urandom);
    return c;
  endfunction

  function command_t poll_cmd(bit q, bit [TAG_W-1:0] status, bit [TAG_W-1:0] cid,
                              bit [TAG_W-1:0] qid, bit fatal);
    command_t c;
    c.mode = MODE_POLL;
    c.queue_sel = q;
    c.status = status;
    c.entry_cid = cid;
    c.entry_qid = qid;
    c.fatal = fatal;
    return c;
  endfunction

  function command_t good_poll(bit q);
    return poll_cmd(q, TAG_W'(sb.exp_phase[q]), sb.wait_tag[q], TAG_W'(q), 1'($urandom));
  endfunction

  function command_t miss_poll(bit q, bit fatal);
    return poll_cmd(q, {15'($urandom), ~sb.exp_phase[q]}, TAG_W'($urandom),
                    TAG_W'($urandom), fatal);
  endfunction

  // Mostly well-formed traffic: submit on an idle queue, then polls that
  // miss, complete cleanly or carry a bad entry; a little pure noise.
  function command_t next_command();
    command_t c;
    bit       q;
    int       roll;
    q = 1'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      c = poll_cmd(q, TAG_W'($urandom), TAG_W'($urandom), TAG_W'($urandom), 1'($urandom));
      c.mode = 1'($urandom);
    end else if (!sb.waiting[q]) begin
      c = (roll < 14) ? miss_poll(q, 1'($urandom)) : submit_cmd(q);
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        c = submit_cmd(q);
      end else if (roll < 50) begin
        c = good_poll(q);
      end else if (roll < 82) begin
        c = miss_poll(q, $urandom_range(0, 9) == 0);
      end else begin
        c = good_poll(q);
        case ($urandom_range(0, 2))
          0: c.entry_cid = sb.wait_tag[q] ^ (TAG_W'(1) << $urandom_range(0, TAG_W - 1));
          1: c.entry_qid = $urandom_range(0, 1) ? TAG_W'(~q) : TAG_W'($urandom_range(2, 65535));
          default: c.status = {15'($urandom_range(1, 32767)), sb.exp_phase[q]};
        endcase
      end
    end
    return c;
  endfunction

  task automatic issue(command_t c);
    cmd.valid            <= 1'b1;
    cmd.mode             <= c.mode;
    cmd.queue_sel        <= c.queue_sel;
    cmd.entry_status     <= c.status;
    cmd.entry_command_id <= c.entry_cid;
    cmd.entry_queue_id   <= c.entry_qid;
    cmd.controller_fatal <= c.fatal;
    do @(posedge clk); while (!cmd.ready);
    sb.note_command(c);
  endtask

  task automatic pause(int n);
    cmd.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    cmd.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  // Leaves valid high so back-to-back writes need no second assignment per step.
  task automatic cfg_write(bit [CFG_IDX_W-1:0] idx, bit [CFG_DATA_W-1:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= data;
    do @(posedge clk); while (!cfg.ready);
    sb.set_register(idx, data);
  endtask

  function bit [CFG_DATA_W-1:0] with_junk(int unsigned value, int unsigned mask);
    return $urandom_range(0, 1) ? (value | ($urandom & ~mask)) : value;
  endfunction

  always @(posedge clk) begin
    result_t got;
    if (rst_n && rsp.valid && rsp.ready) begin
      got.outcome = rsp.outcome;
      got.tag = rsp.command_tag;
      got.slot = rsp.slot_index;
      got.bell = rsp.doorbell_write;
      got.addr = rsp.doorbell_addr;
      got.value = rsp.doorbell_value;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((cmd.valid && cmd.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Result side: stretches of full rate, light and heavy stalls, one long hold.
  initial begin
    int style;
    int len;
    rsp.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        rsp.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        style = $urandom_range(0, 2);
        len = $urandom_range(8, 48);
        repeat (len) begin
          case (style)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= $urandom_range(0, 3) != 0;
            default: rsp.ready <= 1'($urandom);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    int unsigned depth_set [PHASES];
    int unsigned shift_set [PHASES];
    int unsigned limit_set [PHASES];
    int          burst_left;
    depth_set = '{4096, 5, 1, 8191, 2, 0};
    shift_set = '{17, 31, 0, 9, 2, 12};
    limit_set = '{32'hFFFF_FFFF, 0, 3, 7, 1, 4};
    sb = new();
    cmd.valid            <= 1'b0;
    cmd.mode             <= MODE_SUBMIT;
    cmd.queue_sel        <= ADMIN_Q;
    cmd.entry_status     <= '0;
    cmd.entry_command_id <= '0;
    cmd.entry_queue_id   <= '0;
    cmd.controller_fatal <= 1'b0;
    cfg.valid            <= 1'b0;
    cfg.index            <= CFG_QUEUE_DEPTH;
    cfg.data             <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Short poll limit so a timeout shows up in the directed part.
    cfg_write(CFG_POLL_LIMIT, 2);
    cfg.valid <= 1'b0;

    issue(submit_cmd(ADMIN_Q));
    issue(submit_cmd(ADMIN_Q));                       // submit while waiting
    issue(poll_cmd(IO_Q, '1, '1, '1, 1'b1));          // poll while idle
    issue(poll_cmd(ADMIN_Q, {15'h7FFF, ~sb.exp_phase[ADMIN_Q]}, '1, '1, 1'b0));
    issue(poll_cmd(ADMIN_Q, {15'h0, ~sb.exp_phase[ADMIN_Q]}, '0, '0, 1'b0));
    issue(submit_cmd(ADMIN_Q));
    issue(miss_poll(ADMIN_Q, 1'b1));                  // fatal controller
    issue(submit_cmd(IO_Q));
    issue(poll_cmd(IO_Q, TAG_W'(sb.exp_phase[IO_Q]), sb.wait_tag[IO_Q], TAG_W'(IO_Q), 1'b1));
    issue(submit_cmd(IO_Q));
    issue(poll_cmd(IO_Q, TAG_W'(sb.exp_phase[IO_Q]), ~sb.wait_tag[IO_Q], TAG_W'(IO_Q), 1'b0));
    issue(submit_cmd(IO_Q));
    issue(poll_cmd(IO_Q, TAG_W'(sb.exp_phase[IO_Q]), sb.wait_tag[IO_Q], '1, 1'b0));
    issue(submit_cmd(ADMIN_Q));
    issue(poll_cmd(ADMIN_Q, {15'h4000, sb.exp_phase[ADMIN_Q]}, sb.wait_tag[ADMIN_Q],
                   TAG_W'(ADMIN_Q), 1'b0));
    issue(submit_cmd(ADMIN_Q));
    issue(good_poll(ADMIN_Q));
    issue(submit_cmd(IO_Q));
    issue(poll_cmd(IO_Q, TAG_W'(sb.exp_phase[IO_Q]), sb.wait_tag[IO_Q], TAG_W'(ADMIN_Q), 1'b0));

    // Close any open wait, then one clean round on each pair.
    for (int i = 0; i < QUEUE_PAIRS; i++)
      if (sb.waiting[i]) issue(good_poll(1'(i)));
    issue(submit_cmd(ADMIN_Q));
    issue(good_poll(ADMIN_Q));
    issue(submit_cmd(IO_Q));
    issue(good_poll(IO_Q));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      cfg_write(CFG_QUEUE_DEPTH, with_junk(depth_set[p], 32'h1FFF));
      cfg_write(CFG_STRIDE_SHIFT, with_junk(shift_set[p], 32'h1F));
      cfg_write(CFG_POLL_LIMIT, limit_set[p]);
      cfg.valid <= 1'b0;
      burst_left = 0;
      if (p == 0) begin
        // Hold the result side off and keep offering until the input stalls.
        hold_req = 1'b1;
        wait (!hold_req);
        burst_left = 60;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 2 && i == PHASE_ITEMS / 2) drain();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 8));
        end
        burst_left--;
        issue(next_command());
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (sb.awaited.size() != 0) sb.report("expected results never arrived");
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[nvme_queue_pair_tracker.f]
design/nqpt_pkg.sv
design/nqpt_cmd_if.sv
design/nqpt_rsp_if.sv
design/nqpt_cfg_if.sv
design/nqpt_wrap_unit.sv
design/nvme_queue_pair_tracker.sv
tb/sv/testbench.sv
